### hdl/rtd_pkg.sv
// Shared types and constants for the platinum RTD resistance-to-temperature converter.
`default_nettype none
package rtd_pkg;
    localparam int SQRT_STEPS = 56;
    localparam int DIV_STEPS  = 25;
    localparam int FRONT_DEPTH = 6;
    localparam int PIPE_DEPTH = FRONT_DEPTH + SQRT_STEPS + DIV_STEPS + 3;

    localparam logic [1:0] CFG_REF_RES = 2'd0;
    localparam logic [1:0] CFG_COEF_A  = 2'd1;
    localparam logic [1:0] CFG_COEF_B  = 2'd2;

    localparam logic [23:0] RST_REF_RES = 24'd1024000;
    localparam logic [31:0] RST_COEF_A  = 32'd16786021;
    localparam logic [39:0] RST_COEF_B  = 40'hFF64F8778F;

    localparam logic [23:0] ERR_TEMP     = 24'd2559744;
    localparam logic [24:0] TEMP_POS_MAX = 25'd8388607;
    localparam logic [24:0] TEMP_NEG_MAX = 25'd8388608;

    typedef struct packed {
        logic        err;
        logic        a_neg;
        logic        b_neg;
        logic [54:0] p;
        logic [62:0] q;
    } side_t;
endpackage
`default_nettype wire

### hdl/rtd_ifs.sv
// Valid/ready channel interfaces for resistance samples and temperature results.
`default_nettype none
interface rtd_sample_if;
    logic        valid;
    logic        ready;
    logic [23:0] resistance;
    modport source (output valid, output resistance, input ready);
    modport sink (input valid, input resistance, output ready);
endinterface

interface rtd_result_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] temperature;
    logic               valid_res;
    modport source (output valid, output temperature, output valid_res, input ready);
    modport sink (input valid, input temperature, input valid_res, output ready);
endinterface
`default_nettype wire

### hdl/rtd_front.sv
// Front pipeline: coefficient magnitudes, products and the discriminant W.
`default_nettype none
module rtd_front import rtd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         in_valid,
    input  logic [23:0]  in_res,
    input  logic [23:0]  r0,
    input  logic [31:0]  coef_a,
    input  logic [39:0]  coef_b,
    output logic         out_valid,
    output logic [111:0] out_w,
    output side_t        out_side
);
    logic [FRONT_DEPTH-1:0] v_reg;

    logic [31:0]  am_next;
    logic [39:0]  bm_next;
    logic         dn_next;
    logic [23:0]  dm_next;

    logic [23:0]  r0_1_reg;
    logic [31:0]  am_1_reg;
    logic [39:0]  bm_1_reg;
    logic         an_1_reg, bn_1_reg, dn_1_reg;
    logic [23:0]  dm_1_reg;

    logic [55:0]  p_full;
    logic [43:0]  qlo_full, qhi_full;
    logic [54:0]  p_2_reg;
    logic [43:0]  qlo_2_reg, qhi_2_reg;
    logic         an_2_reg, bn_2_reg, dn_2_reg;
    logic [23:0]  dm_2_reg;

    logic [63:0]  q_sum;
    logic [55:0]  ll_full;
    logic [54:0]  lh_full;
    logic [53:0]  hh_full;
    logic [62:0]  q_3_reg;
    logic [54:0]  p_3_reg;
    logic [55:0]  ll_3_reg;
    logic [54:0]  lh_3_reg;
    logic [53:0]  hh_3_reg;
    logic         an_3_reg, bn_3_reg, dn_3_reg;
    logic [23:0]  dm_3_reg;

    logic [111:0] w_sum;
    logic [55:0]  tl_full;
    logic [54:0]  th_full;
    logic [111:0] w_4_reg;
    logic [55:0]  tl_4_reg;
    logic [54:0]  th_4_reg;
    side_t        s_4_reg;
    logic         dn_4_reg;

    logic [111:0] term_sum;
    logic [111:0] w_5_reg, term_5_reg;
    side_t        s_5_reg;
    logic         dn_5_reg;

    logic [112:0] diff;
    logic [111:0] w_next;
    side_t        s_next;
    logic [111:0] w_6_reg;
    side_t        s_6_reg;

    always_comb
    begin
        am_next = coef_a[31] ? (~coef_a + 32'd1) : coef_a;
        bm_next = coef_b[39] ? (~coef_b + 40'd1) : coef_b;
        dn_next = in_res > r0;
        dm_next = dn_next ? (in_res - r0) : (r0 - in_res);
    end

    assign p_full   = 56'(r0_1_reg) * 56'(am_1_reg);
    assign qlo_full = 44'(r0_1_reg) * 44'(bm_1_reg[19:0]);
    assign qhi_full = 44'(r0_1_reg) * 44'(bm_1_reg[39:20]);

    assign q_sum   = {qhi_2_reg, 20'b0} + 64'(qlo_2_reg);
    assign ll_full = 56'(p_2_reg[27:0]) * 56'(p_2_reg[27:0]);
    assign lh_full = 55'(p_2_reg[27:0]) * 55'(p_2_reg[54:28]);
    assign hh_full = 54'(p_2_reg[54:28]) * 54'(p_2_reg[54:28]);

    assign w_sum   = 112'({hh_3_reg, 56'b0}) + 112'({lh_3_reg, 29'b0}) + 112'(ll_3_reg);
    assign tl_full = 56'(q_3_reg[31:0]) * 56'(dm_3_reg);
    assign th_full = 55'(q_3_reg[62:32]) * 55'(dm_3_reg);

    assign term_sum = (112'({th_4_reg, 32'b0}) + 112'(tl_4_reg)) << 14;

    always_comb
    begin
        diff   = {1'b0, w_5_reg} - {1'b0, term_5_reg};
        s_next = s_5_reg;
        if (s_5_reg.b_neg != dn_5_reg)
        begin
            w_next = w_5_reg + term_5_reg;
        end
        else
        begin
            w_next = diff[111:0];
            s_next.err = s_5_reg.err | diff[112];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[FRONT_DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_1_reg  <= r0;
            am_1_reg  <= am_next;
            bm_1_reg  <= bm_next;
            an_1_reg  <= coef_a[31];
            bn_1_reg  <= coef_b[39];
            dn_1_reg  <= dn_next;
            dm_1_reg  <= dm_next;

            p_2_reg   <= p_full[54:0];
            qlo_2_reg <= qlo_full;
            qhi_2_reg <= qhi_full;
            an_2_reg  <= an_1_reg;
            bn_2_reg  <= bn_1_reg;
            dn_2_reg  <= dn_1_reg;
            dm_2_reg  <= dm_1_reg;

            q_3_reg   <= q_sum[62:0];
            p_3_reg   <= p_2_reg;
            ll_3_reg  <= ll_full;
            lh_3_reg  <= lh_full;
            hh_3_reg  <= hh_full;
            an_3_reg  <= an_2_reg;
            bn_3_reg  <= bn_2_reg;
            dn_3_reg  <= dn_2_reg;
            dm_3_reg  <= dm_2_reg;

            w_4_reg       <= w_sum;
            tl_4_reg      <= tl_full;
            th_4_reg      <= th_full;
            s_4_reg.err   <= (q_3_reg == '0);
            s_4_reg.a_neg <= an_3_reg;
            s_4_reg.b_neg <= bn_3_reg;
            s_4_reg.p     <= p_3_reg;
            s_4_reg.q     <= q_3_reg;
            dn_4_reg      <= dn_3_reg;

            w_5_reg    <= w_4_reg;
            term_5_reg <= term_sum;
            s_5_reg    <= s_4_reg;
            dn_5_reg   <= dn_4_reg;

            w_6_reg <= w_next;
            s_6_reg <= s_next;
        end
    end

    assign out_valid = v_reg[FRONT_DEPTH-1];
    assign out_w     = w_6_reg;
    assign out_side  = s_6_reg;
endmodule
`default_nettype wire

### hdl/rtd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module rtd_sqrt import rtd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         in_valid,
    input  logic [111:0] in_w,
    input  side_t        in_side,
    output logic         out_valid,
    output logic [55:0]  out_root,
    output side_t        out_side
);
    logic [SQRT_STEPS-1:0] v_reg;
    logic [111:0]          w_reg    [SQRT_STEPS];
    logic [58:0]           rem_reg  [SQRT_STEPS];
    logic [55:0]           root_reg [SQRT_STEPS];
    side_t                 side_reg [SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[SQRT_STEPS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic [111:0] w_in;
        logic [58:0]  rem_in;
        logic [55:0]  root_in;
        side_t        side_in;
        logic [58:0]  cur, trial;
        logic         take;

        if (k == 0)
        begin : g_first
            assign w_in    = in_w;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign w_in    = w_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign cur   = {rem_in[56:0], w_in[111-2*k -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign take  = cur >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                w_reg[k]    <= w_in;
                side_reg[k] <= side_in;
                rem_reg[k]  <= take ? (cur - trial) : cur;
                root_reg[k] <= {root_in[54:0], take};
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign out_root  = root_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];
endmodule
`default_nettype wire

### hdl/rtd_div.sv
// Numerator, rounding divide, saturation and error substitution.
`default_nettype none
module rtd_div import rtd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [55:0]        in_root,
    input  side_t              in_side,
    output logic               out_valid,
    output logic signed [23:0] out_temp,
    output logic               out_ok
);
    localparam int DEPTH = DIV_STEPS + 3;

    logic [DEPTH-1:0] v_reg;

    logic [56:0] n_next;
    logic        n_neg;
    logic [56:0] n_a_reg;
    logic        neg_a_reg, err_a_reg;
    logic [62:0] q_a_reg;

    logic [85:0] num_full;
    logic        ovf_next;
    logic [85:0] num_b_reg;
    logic [63:0] d_b_reg;
    logic        ovf_b_reg, neg_b_reg, err_b_reg;

    logic [85:0] rem_reg [DIV_STEPS];
    logic [24:0] quo_reg [DIV_STEPS];
    logic [63:0] d_reg   [DIV_STEPS];
    logic        ovf_reg [DIV_STEPS];
    logic        neg_reg [DIV_STEPS];
    logic        err_reg [DIV_STEPS];

    logic [24:0]        mag;
    logic signed [23:0] temp_next;
    logic signed [23:0] temp_reg;
    logic               ok_reg;

    always_comb
    begin
        n_neg = 1'b0;
        if (in_side.a_neg)
        begin
            n_next = 57'(in_root) + 57'(in_side.p);
        end
        else if (in_root >= 56'(in_side.p))
        begin
            n_next = 57'(in_root) - 57'(in_side.p);
        end
        else
        begin
            n_next = 57'(in_side.p) - 57'(in_root);
            n_neg  = 1'b1;
        end
    end

    assign num_full = {1'b0, n_a_reg, 28'b0} + 86'(q_a_reg);
    assign ovf_next = {3'b0, num_full} >= {q_a_reg, 26'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_a_reg   <= n_next;
            neg_a_reg <= n_neg ^ in_side.b_neg;
            err_a_reg <= in_side.err;
            q_a_reg   <= in_side.q;

            num_b_reg <= num_full;
            d_b_reg   <= {q_a_reg, 1'b0};
            ovf_b_reg <= ovf_next;
            neg_b_reg <= neg_a_reg;
            err_b_reg <= err_a_reg;
        end
    end

    // Restoring divide: the quotient is known to be below 2^25 unless overflow is flagged.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        localparam int SH = DIV_STEPS - 1 - k;
        logic [85:0] rem_in;
        logic [24:0] quo_in;
        logic [63:0] d_in;
        logic        ovf_in, neg_in, err_in;
        logic [88:0] trial;
        logic        take;

        if (k == 0)
        begin : g_first
            assign rem_in = num_b_reg;
            assign quo_in = '0;
            assign d_in   = d_b_reg;
            assign ovf_in = ovf_b_reg;
            assign neg_in = neg_b_reg;
            assign err_in = err_b_reg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign err_in = err_reg[k-1];
        end

        assign trial = 89'(d_in) << SH;
        assign take  = 89'(rem_in) >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= take ? 86'(89'(rem_in) - trial) : rem_in;
                quo_reg[k] <= {quo_in[23:0], take};
                d_reg[k]   <= d_in;
                ovf_reg[k] <= ovf_in;
                neg_reg[k] <= neg_in;
                err_reg[k] <= err_in;
            end
        end
    end

    always_comb
    begin
        if (neg_reg[DIV_STEPS-1])
        begin
            mag = (ovf_reg[DIV_STEPS-1] || quo_reg[DIV_STEPS-1] > TEMP_NEG_MAX)
                ? TEMP_NEG_MAX : quo_reg[DIV_STEPS-1];
            temp_next = signed'(24'(~mag + 25'd1));
        end
        else
        begin
            mag = (ovf_reg[DIV_STEPS-1] || quo_reg[DIV_STEPS-1] > TEMP_POS_MAX)
                ? TEMP_POS_MAX : quo_reg[DIV_STEPS-1];
            temp_next = signed'(mag[23:0]);
        end
        if (err_reg[DIV_STEPS-1])
        begin
            temp_next = signed'(ERR_TEMP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            temp_reg <= temp_next;
            ok_reg   <= ~err_reg[DIV_STEPS-1];
        end
    end

    assign out_valid = v_reg[DEPTH-1];
    assign out_temp  = temp_reg;
    assign out_ok    = ok_reg;
endmodule
`default_nettype wire

### hdl/platinum_rtd_resistance_to_temp.sv
// Top level of the platinum RTD resistance-to-temperature converter.
// Converts a measured sensor resistance (1/1024 ohm) to temperature (1/256 degree C)
// with the inverse quadratic Callendar-Van Dusen form. The block is a fixed 90-stage
// pipeline: it takes one sample every cycle when the output side keeps ready high.
// The length is set by the square root (one root bit per stage, 56 stages) and the
// rounding divide (one quotient bit per stage, 25 stages), plus six front stages for
// products and the discriminant and three more for the numerator, the rounding
// offset and the saturated output.
// A stall on the result channel freezes the whole pipeline; nothing is lost.
// Write the coefficients only while no sample is in flight. A negative discriminant
// or a zero divisor yields 9999 degrees with valid_res low; results out of range
// saturate with valid_res high.
`default_nettype none
module platinum_rtd_resistance_to_temp import rtd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_idx,
    input  logic [39:0]  cfg_data,
    rtd_sample_if.sink   sample,
    rtd_result_if.source result
);
    logic [23:0]  r0_reg;
    logic [31:0]  coef_a_reg;
    logic [39:0]  coef_b_reg;

    logic         adv;
    logic         fr_valid;
    logic [111:0] fr_w;
    side_t        fr_side;
    logic         sq_valid;
    logic [55:0]  sq_root;
    side_t        sq_side;

    logic [6:0]   inflight_reg;
    logic [6:0]   inflight_next;

    // Advance every stage whenever the output stage is empty or being drained.
    assign adv          = !result.valid || result.ready;
    assign sample.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_reg     <= RST_REF_RES;
            coef_a_reg <= RST_COEF_A;
            coef_b_reg <= RST_COEF_B;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_REF_RES: r0_reg     <= cfg_data[23:0];
                CFG_COEF_A:  coef_a_reg <= cfg_data[31:0];
                CFG_COEF_B:  coef_b_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    rtd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sample.valid),
        .in_res    (sample.resistance),
        .r0        (r0_reg),
        .coef_a    (coef_a_reg),
        .coef_b    (coef_b_reg),
        .out_valid (fr_valid),
        .out_w     (fr_w),
        .out_side  (fr_side)
    );

    rtd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_w      (fr_w),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    rtd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (result.valid),
        .out_temp  (result.temperature),
        .out_ok    (result.valid_res)
    );

    // Track beats in flight for the checks below.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (sample.valid && sample.ready)
        begin
            inflight_next = inflight_next + 7'd1;
        end
        if (result.valid && result.ready)
        begin
            inflight_next = inflight_next - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.valid_res |-> result.temperature == signed'(ERR_TEMP))
        else $error("error result without the error temperature");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> inflight_reg != 7'd0)
        else $error("result beat with no sample in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 7'(PIPE_DEPTH))
        else $error("more beats in flight than pipeline stages");
endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the platinum RTD resistance-to-temperature converter.
`default_nettype none

// Expected-result store plus a bit-exact predictor of the conversion.
class temp_scoreboard;
    typedef struct {
        logic signed [23:0] temperature;
        logic               valid_res;
    } temp_exp_t;

    logic [23:0] r0;
    logic [31:0] coef_a;
    logic [39:0] coef_b;
    temp_exp_t   temps_due[$];
    int          mismatches;

    function void set_coefs(logic [23:0] r0_v, logic [31:0] a_v, logic [39:0] b_v);
        r0 = r0_v;
        coef_a = a_v;
        coef_b = b_v;
    endfunction

    function temp_exp_t convert(logic [23:0] r);
        temp_exp_t    t;
        logic         a_neg, b_neg, d_neg, n_neg;
        logic [63:0]  a_mag, b_mag, d_mag, p, q, s, n_mag, m;
        logic [127:0] w, term, c, num, quo;
        t.temperature = rtd_pkg::ERR_TEMP;
        t.valid_res   = 1'b0;
        a_neg = coef_a[31];
        b_neg = coef_b[39];
        a_mag = a_neg ? (64'd1 << 32) - {32'd0, coef_a} : {32'd0, coef_a};
        b_mag = b_neg ? (64'd1 << 40) - {24'd0, coef_b} : {24'd0, coef_b};
        q = {40'd0, r0} * b_mag;
        if (q == 0)
            return t;
        d_neg = r > r0;
        d_mag = d_neg ? {40'd0, r - r0} : {40'd0, r0 - r};
        p = {40'd0, r0} * a_mag;
        w = {64'd0, p} * {64'd0, p};
        if (d_mag != 0)
        begin
            term = ({64'd0, q} * {64'd0, d_mag}) << 14;
            if (b_neg != d_neg)
                w = w + term;
            else if (term > w)
                return t;   // negative discriminant
            else
                w = w - term;
        end
        // integer square root, one bit at a time
        s = 0;
        for (int k = 55; k >= 0; k--)
        begin
            c = {64'd0, s | (64'd1 << k)};
            if (c * c <= w)
                s = c[63:0];
        end
        if (a_neg)
        begin
            n_neg = 1'b0;
            n_mag = s + p;
        end
        else if (s >= p)
        begin
            n_neg = 1'b0;
            n_mag = s - p;
        end
        else
        begin
            n_neg = 1'b1;
            n_mag = p - s;
        end
        // round half away from zero
        num = ({64'd0, n_mag} << 28) + {64'd0, q};
        quo = num / ({64'd0, q} << 1);
        if (n_neg != b_neg)
        begin
            m = (quo > 128'd8388608) ? 64'd8388608 : quo[63:0];
            t.temperature = -m[23:0];
        end
        else
        begin
            m = (quo > 128'd8388607) ? 64'd8388607 : quo[63:0];
            t.temperature = m[23:0];
        end
        t.valid_res = 1'b1;
        return t;
    endfunction

    function void note_sample(logic [23:0] r);
        temps_due.push_back(convert(r));
    endfunction

    function void check_result(logic signed [23:0] temp, logic vres);
        temp_exp_t e;
        if (temps_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result temp=%0d valid_res=%0b", temp, vres);
            return;
        end
        e = temps_due.pop_front();
        if (temp !== e.temperature || vres !== e.valid_res)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: temp exp %0d got %0d, valid_res exp %0b got %0b",
                         e.temperature, temp, e.valid_res, vres);
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rtd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int NUM_PHASES = 8;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [39:0] cfg_data;

    rtd_sample_if sample ();
    rtd_result_if result ();

    platinum_rtd_resistance_to_temp uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .sample   (sample.sink),
        .result   (result.source)
    );

    temp_scoreboard sb;

    // set while the receiver holds off; the sender then pushes back to back
    logic  hold_off;
    // raised by the main sequence at the start of a phase to ask for the hold-off
    logic  hold_req;
    logic  send_burst;
    logic  recv_burst;
    bit    hold_done;
    int    results_seen;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a stuck handshake ends the run here.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Write one register: raise the enable, wait for a falling edge, then drop it.
    task automatic write_reg(logic [1:0] idx, logic [39:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_coefs(logic [23:0] r0, logic [31:0] a, logic [39:0] b);
        write_reg(CFG_REF_RES, {16'd0, r0});
        write_reg(CFG_COEF_A, {8'd0, a});
        write_reg(CFG_COEF_B, b);
        sb.set_coefs(r0, a, b);
    endtask

    // Offer one sample beat after an optional idle gap; return at the falling edge after
    // the beat is taken, with valid dropped. Called at a falling edge.
    task automatic send_sample(logic [23:0] r);
        int gap;
        gap = (send_burst || hold_off) ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            sample.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample.valid      = 1'b1;
        sample.resistance = r;
        do
            @(posedge clk);
        while (!sample.ready);
        sb.note_sample(r);
        @(negedge clk);
        sample.valid = 1'b0;
    endtask

    // Draw a resistance: mostly near the zero-degree point, sometimes anything.
    function automatic logic [23:0] pick_resistance(logic [23:0] r0);
        longint v;
        if ($urandom_range(0, 3) == 0)
            return 24'($urandom_range(0, 24'hFFFFFF));
        v = longint'(r0) / 2 + longint'($urandom_range(0, 2 * r0));
        if (v > 24'hFFFFFF)
            v = $urandom_range(0, 24'hFFFFFF);
        return v[23:0];
    endfunction

    // Wait until every result is back, then let the pipeline drain.
    task automatic wait_idle();
        while (sb.temps_due.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 10) @(negedge clk);
    endtask

    // Receiver: random ready gaps, one long hold-off to back up the pipeline.
    initial
    begin
        int gap;
        results_seen = 0;
        hold_off     = 1'b0;
        hold_done    = 1'b0;
        result.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!hold_done && hold_req && results_seen >= 300)
            begin
                hold_done    = 1'b1;
                hold_off     = 1'b1;
                result.ready = 1'b0;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            gap = recv_burst ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                result.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            result.ready = 1'b1;
            do
                @(posedge clk);
            while (!result.valid);
            sb.check_result(result.temperature, result.valid_res);
            results_seen++;
            @(negedge clk);
        end
    end

    // Main sequence: reset, directed corners, then random phases over settings.
    initial
    begin
        logic [23:0] r0_v;
        logic [31:0] a_v;
        logic [39:0] b_v;
        sb = new();
        sb.set_coefs(RST_REF_RES, RST_COEF_A, RST_COEF_B);
        hold_req          = 1'b0;
        send_burst        = 1'b0;
        recv_burst        = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_REF_RES;
        cfg_data          = '0;
        sample.valid      = 1'b0;
        sample.resistance = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes, zero degrees, neighbors, bit patterns and a
        // resistance high enough to make the discriminant negative.
        send_sample(24'd0);
        send_sample(24'hFFFFFF);
        send_sample(RST_REF_RES);
        send_sample(RST_REF_RES - 1);
        send_sample(RST_REF_RES + 1);
        send_sample(24'hAAAAAA);
        send_sample(24'h555555);
        send_sample(24'd1);
        send_sample(24'd400000);
        send_sample(24'd4000000);
        send_sample(24'd8000000);
        wait_idle();
        // Zero divisor, and a zero reference resistance
        load_coefs(24'd1024000, RST_COEF_A, 40'd0);
        send_sample(24'd1024000);
        send_sample(24'd0);
        wait_idle();
        load_coefs(24'd0, RST_COEF_A, RST_COEF_B);
        send_sample(24'd1024000);
        wait_idle();
        // Coefficient extremes, saturation both ways
        load_coefs(24'hFFFFFF, 32'h8000_0000, 40'h7F_FFFF_FFFF);
        send_sample(24'd0);
        send_sample(24'hFFFFFF);
        send_sample(24'h7FFFFF);
        wait_idle();
        load_coefs(24'd1, 32'h7FFF_FFFF, 40'h80_0000_0000);
        send_sample(24'd0);
        send_sample(24'd1);
        send_sample(24'hFFFFFF);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    r0_v = RST_REF_RES;
                    a_v  = RST_COEF_A;
                    b_v  = RST_COEF_B;
                end
                1:
                begin
                    r0_v = 24'd102400;
                    a_v  = RST_COEF_A;
                    b_v  = RST_COEF_B;
                end
                2:
                begin
                    r0_v = 24'hFFFFFF;
                    a_v  = 32'h8000_0000;
                    b_v  = 40'h80_0000_0000;
                end
                3:
                begin
                    r0_v = 24'd1;
                    a_v  = 32'h7FFF_FFFF;
                    b_v  = 40'h7F_FFFF_FFFF;
                end
                4:
                begin
                    r0_v = 24'd1024000;
                    a_v  = RST_COEF_A;
                    b_v  = 40'd0;
                end
                default:
                begin
                    r0_v = 24'($urandom_range(1, 24'hFFFFFF));
                    a_v  = $urandom();
                    b_v  = {8'($urandom_range(0, 255)), $urandom()};
                end
            endcase
            load_coefs(r0_v, a_v, b_v);
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            // ask for the long hold-off while a whole phase of samples is still to come
            if (ph == 2)
                hold_req = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_sample(pick_resistance(r0_v));
            sample.valid = 1'b0;
            wait_idle();
        end
        load_coefs(RST_REF_RES, RST_COEF_A, RST_COEF_B);

        if (sb.mismatches == 0 && sb.temps_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
